@@ rtl/core/dles_pkg.sv @@
// ----------------------------------------------------------------------------
// dles_pkg
// Shared sizes, operation codes and result kinds of the delta-list scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dles_pkg;

  // Unit set and delay sizes
  localparam int NUM_UNITS  = 16;
  localparam int UNIT_BITS  = $clog2(NUM_UNITS);
  localparam int LINK_BITS  = UNIT_BITS + 1;
  localparam int DELAY_BITS = 24;
  localparam int CD_BITS    = DELAY_BITS + 2;
  localparam int ACC_BITS   = DELAY_BITS + UNIT_BITS + 1;
  localparam int TTF_BITS   = 25;
  localparam int COUNT_BITS = 5;
  localparam int OP_BITS    = 3;
  localparam int KIND_BITS  = 2;
  localparam int IDLE_BITS  = 24;

  localparam logic [LINK_BITS-1:0]  LIST_END   = LINK_BITS'(NUM_UNITS);
  localparam logic [DELAY_BITS-1:0] DELAY_MAX  = {DELAY_BITS{1'b1}};
  localparam logic [TTF_BITS-1:0]   TTF_MAX    = {TTF_BITS{1'b1}};
  localparam logic [IDLE_BITS-1:0]  IDLE_RESET = IDLE_BITS'(1000000);

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_ACTIVATE   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_RESCHEDULE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_CANCEL     = 3'd2;
  localparam logic [OP_BITS-1:0] OP_ADVANCE    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_QUERY      = 3'd4;

  // Result kinds
  localparam logic [KIND_BITS-1:0] KIND_FIRED = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_ACK   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_QUERY = 2'd2;

endpackage

`default_nettype wire

@@ rtl/core/dles_ifs.sv @@
// ----------------------------------------------------------------------------
// dles_ifs
// Valid/ready channels of the scheduler: request, response and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface dles_req_if;
  logic                         valid;
  logic                         ready;
  logic [dles_pkg::OP_BITS-1:0] operation;
  logic [3:0]                   unit;
  logic [23:0]                  delay;
  modport source (output valid, output operation, output unit, output delay, input ready);
  modport sink   (input valid, input operation, input unit, input delay, output ready);
endinterface

interface dles_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  unit_out;
  logic [24:0] time_to_fire;
  logic        is_active;
  logic [4:0]  queue_count;
  logic        last;
  modport source (output valid, output result_kind, output unit_out, output time_to_fire,
                  output is_active, output queue_count, output last, input ready);
  modport sink   (input valid, input result_kind, input unit_out, input time_to_fire,
                  input is_active, input queue_count, input last, output ready);
endinterface

interface dles_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] idle_interval;
  modport source (output valid, output idle_interval, input ready);
  modport sink   (input valid, input idle_interval, output ready);
endinterface

`default_nettype wire

@@ rtl/core/delta_list_event_scheduler.sv @@
// ----------------------------------------------------------------------------
// delta_list_event_scheduler
// Clock-ordered event queue kept as a delta list over a fixed set of units.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  --------+-----+--------------------------------------------------------------
//  req     | in  | operation, unit, delay
//  rsp     | out | result_kind, unit_out, time_to_fire, is_active, queue_count, last
//  cfg     | in  | idle_interval (always ready)
//
//  One request at a time; req.ready is high only in the idle state.
//  The list is walked one entry a cycle through one shared adder/comparator.
//  Activate, cancel and query walk past up to 16 entries; reschedule of a
//  queued unit walks twice, and activating a queued unit or cancelling an
//  idle one skips the walk. Advance pops each due unit in turn and returns
//  one result per fired unit, or a single ack when nothing is due.
//  Each result sits in an output register; a stalled rsp holds the sequencer.
//  Synchronous reset empties the queue and restores idle_interval to 1000000.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_event_scheduler (
  input  wire       clk,
  input  wire       rst,
  dles_req_if.sink  req,
  dles_rsp_if.source rsp,
  dles_cfg_if.sink  cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_SYNC, S_A_WALK, S_A_LINK, S_A_FIX, S_C_WALK, S_C_LINK, S_C_FIX,
    S_RELOAD, S_ADV_CHK, S_POP, S_P_RELOAD, S_P_EMIT, S_Q_WALK, S_RESP
  } state_t;

  localparam int LB = dles_pkg::LINK_BITS;
  localparam int UB = dles_pkg::UNIT_BITS;
  localparam int DB = dles_pkg::DELAY_BITS;
  localparam int AB = dles_pkg::ACC_BITS;
  localparam int CB = dles_pkg::CD_BITS;
  localparam int TB = dles_pkg::TTF_BITS;

  state_t state;

  // List storage
  logic [LB-1:0] link_next  [dles_pkg::NUM_UNITS];
  logic [DB-1:0] delta_time [dles_pkg::NUM_UNITS];
  logic [dles_pkg::NUM_UNITS-1:0] queued_flag;
  logic [LB-1:0] head_index;
  logic signed [CB-1:0] countdown;
  logic [dles_pkg::COUNT_BITS-1:0] entry_count;
  logic [dles_pkg::IDLE_BITS-1:0] idle_interval;

  // Latched request and walk registers
  logic [dles_pkg::OP_BITS-1:0] op;
  logic [UB-1:0] unit_r;
  logic [DB-1:0] delay_r;
  logic [LB-1:0] cur, prev, succ;
  logic [AB-1:0] accum;
  logic [DB-1:0] dsave;
  logic [TB-1:0] ttf;
  logic [UB-1:0] popped;

  // Shared walk datapath
  logic [UB-1:0] cur_idx;
  logic [DB-1:0] cur_delta;
  logic [LB-1:0] cur_link;
  logic [AB-1:0] acc_sum;
  logic [AB:0]   ttf_sum;
  logic          cur_end;
  logic          cd_le_zero;
  logic          head_end;
  logic          out_free;
  logic          emit_now;
  logic [DB:0]   merge_sum;
  logic [UB-1:0] head_idx;

  assign cur_idx    = cur[UB-1:0];
  assign cur_end    = (cur == dles_pkg::LIST_END);
  assign cur_delta  = delta_time[cur_idx];
  assign cur_link   = link_next[cur_idx];
  assign acc_sum    = accum + AB'(cur_delta);
  assign ttf_sum    = {1'b0, acc_sum} + (AB+1)'(1);
  assign cd_le_zero = countdown[CB-1] || (countdown == '0);
  assign head_end   = (head_index == dles_pkg::LIST_END);
  assign head_idx   = head_index[UB-1:0];
  assign out_free   = !rsp.valid || rsp.ready;
  assign emit_now   = ((state == S_RESP) || (state == S_P_EMIT)) && out_free;
  assign merge_sum  = {1'b0, cur_delta} + {1'b0, dsave};

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idle_interval <= dles_pkg::IDLE_RESET;
      countdown     <= CB'(dles_pkg::IDLE_RESET);
      head_index    <= dles_pkg::LIST_END;
      entry_count   <= '0;
      queued_flag   <= '0;
      rsp.valid     <= 1'b0;
      for (int i = 0; i < dles_pkg::NUM_UNITS; i++) begin
        link_next[i]  <= dles_pkg::LIST_END;
        delta_time[i] <= '0;
      end
    end else begin
      // configuration write
      if (cfg.valid) begin
        idle_interval <= cfg.idle_interval;
      end
      // output register empties unless a new result goes in
      if (rsp.ready && !emit_now) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op      <= req.operation;
            unit_r  <= req.unit;
            delay_r <= req.delay;
            state   <= S_SYNC;
          end
        end

        // bring the head delta in line with the countdown, then dispatch
        S_SYNC: begin
          if (!head_end) begin
            if (countdown[CB-1]) delta_time[head_idx] <= '0;
            else if (countdown[CB-2:DB] != '0) delta_time[head_idx] <= dles_pkg::DELAY_MAX;
            else delta_time[head_idx] <= countdown[DB-1:0];
          end
          cur   <= head_index;
          prev  <= dles_pkg::LIST_END;
          accum <= '0;
          priority case (op)
            dles_pkg::OP_ACTIVATE:
              state <= queued_flag[unit_r] ? S_RESP : S_A_WALK;
            dles_pkg::OP_RESCHEDULE, dles_pkg::OP_CANCEL:
              state <= queued_flag[unit_r] ? S_C_WALK
                     : (op == dles_pkg::OP_RESCHEDULE) ? S_A_WALK : S_RESP;
            dles_pkg::OP_ADVANCE: begin
              countdown <= countdown - $signed(CB'(delay_r));
              state     <= S_ADV_CHK;
            end
            dles_pkg::OP_QUERY: state <= S_Q_WALK;
            default: state <= S_RESP;
          endcase
        end

        // find the insertion point
        S_A_WALK: begin
          if (cur_end || (AB'(delay_r) < acc_sum)) begin
            state <= S_A_LINK;
          end else begin
            accum <= acc_sum;
            prev  <= cur;
            cur   <= cur_link;
          end
        end

        S_A_LINK: begin
          dsave                  <= delay_r - accum[DB-1:0];
          delta_time[unit_r]     <= delay_r - accum[DB-1:0];
          link_next[unit_r]      <= cur;
          queued_flag[unit_r]    <= 1'b1;
          entry_count            <= entry_count + 1'b1;
          state                  <= S_A_FIX;
        end

        S_A_FIX: begin
          if (prev != dles_pkg::LIST_END) link_next[prev[UB-1:0]] <= LB'(unit_r);
          else head_index <= LB'(unit_r);
          if (!cur_end) delta_time[cur_idx] <= cur_delta - dsave;
          state <= S_RELOAD;
        end

        // find the unit and its predecessor
        S_C_WALK: begin
          if (cur_end) begin
            state <= S_RESP;
          end else if (cur_idx == unit_r) begin
            succ  <= cur_link;
            dsave <= cur_delta;
            state <= S_C_LINK;
          end else begin
            prev <= cur;
            cur  <= cur_link;
          end
        end

        S_C_LINK: begin
          if (prev != dles_pkg::LIST_END) link_next[prev[UB-1:0]] <= succ;
          else head_index <= succ;
          link_next[unit_r]   <= dles_pkg::LIST_END;
          delta_time[unit_r]  <= '0;
          queued_flag[unit_r] <= 1'b0;
          if (entry_count != '0) entry_count <= entry_count - 1'b1;
          cur   <= succ;
          state <= S_C_FIX;
        end

        // fold the removed delta into the successor, saturating
        S_C_FIX: begin
          if (!cur_end) begin
            delta_time[cur_idx] <= merge_sum[DB] ? dles_pkg::DELAY_MAX : merge_sum[DB-1:0];
          end
          state <= S_RELOAD;
        end

        S_RELOAD: begin
          countdown <= head_end ? CB'(idle_interval) : CB'(delta_time[head_idx]);
          cur       <= head_index;
          prev      <= dles_pkg::LIST_END;
          accum     <= '0;
          if (op == dles_pkg::OP_RESCHEDULE && !queued_flag[unit_r]) state <= S_A_WALK;
          else state <= S_RESP;
        end

        S_ADV_CHK: begin
          if (cd_le_zero && !head_end) begin
            state <= S_POP;
          end else begin
            if (cd_le_zero) countdown <= CB'(idle_interval);
            state <= S_RESP;
          end
        end

        // pop the head
        S_POP: begin
          popped                <= head_idx;
          head_index            <= link_next[head_idx];
          link_next[head_idx]   <= dles_pkg::LIST_END;
          delta_time[head_idx]  <= '0;
          queued_flag[head_idx] <= 1'b0;
          if (entry_count != '0) entry_count <= entry_count - 1'b1;
          state <= S_P_RELOAD;
        end

        S_P_RELOAD: begin
          countdown <= head_end ? CB'(idle_interval) : CB'(delta_time[head_idx]);
          state     <= S_P_EMIT;
        end

        S_P_EMIT: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.result_kind  <= dles_pkg::KIND_FIRED;
            rsp.unit_out     <= popped;
            rsp.time_to_fire <= '0;
            rsp.is_active    <= 1'b0;
            rsp.queue_count  <= entry_count;
            rsp.last         <= !(cd_le_zero && !head_end);
            state            <= (cd_le_zero && !head_end) ? S_POP : S_IDLE;
          end
        end

        // sum deltas up to the unit
        S_Q_WALK: begin
          if (cur_end) begin
            ttf   <= '0;
            state <= S_RESP;
          end else if (cur_idx == unit_r) begin
            ttf   <= (ttf_sum > (AB+1)'(dles_pkg::TTF_MAX)) ? dles_pkg::TTF_MAX
                   : ttf_sum[TB-1:0];
            state <= S_RESP;
          end else begin
            accum <= acc_sum;
            cur   <= cur_link;
          end
        end

        S_RESP: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.result_kind  <= (op == dles_pkg::OP_QUERY) ? dles_pkg::KIND_QUERY
                              : dles_pkg::KIND_ACK;
            rsp.unit_out     <= unit_r;
            rsp.time_to_fire <= (op == dles_pkg::OP_QUERY) ? ttf : '0;
            rsp.is_active    <= queued_flag[unit_r];
            rsp.queue_count  <= entry_count;
            rsp.last         <= 1'b1;
            state            <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the delta-list event scheduler against a behavioural model of the
// queue: directed cases, then random operation mixes with random idling.
// ----------------------------------------------------------------------------
`default_nettype none

// Expected result of the scheduler
typedef struct packed {
  logic [dles_pkg::KIND_BITS-1:0]  kind;
  logic [3:0]                      unit;
  logic [dles_pkg::TTF_BITS-1:0]   ttf;
  logic                            active;
  logic [dles_pkg::COUNT_BITS-1:0] count;
  logic                            last;
} sched_result_t;

// Model of the queue plus the store of expected results
class sched_scoreboard;
  logic [dles_pkg::LINK_BITS-1:0]  nxt [dles_pkg::NUM_UNITS];
  logic [dles_pkg::DELAY_BITS-1:0] dlt [dles_pkg::NUM_UNITS];
  bit                              queued [dles_pkg::NUM_UNITS];
  logic [dles_pkg::LINK_BITS-1:0]  head;
  longint                          cdown;
  int                              count;
  logic [dles_pkg::IDLE_BITS-1:0]  idle_ival;
  sched_result_t                   pending [$];
  int                              errors;

  function void clear();
    for (int i = 0; i < dles_pkg::NUM_UNITS; i++) begin
      nxt[i] = dles_pkg::LIST_END;
      dlt[i] = '0;
      queued[i] = 0;
    end
    head = dles_pkg::LIST_END;
    idle_ival = dles_pkg::IDLE_RESET;
    cdown = idle_ival;
    count = 0;
    pending.delete();
    errors = 0;
  endfunction

  function void set_idle(logic [dles_pkg::IDLE_BITS-1:0] v);
    idle_ival = v;
  endfunction

  function void reload();
    if (head < dles_pkg::NUM_UNITS) cdown = dlt[head];
    else cdown = idle_ival;
  endfunction

  function void unlink(int u);
    int cur, prev, succ;
    longint s;
    if (!queued[u]) return;
    cur = head;
    prev = dles_pkg::NUM_UNITS;
    for (int n = 0; n < dles_pkg::NUM_UNITS && cur < dles_pkg::NUM_UNITS && cur != u; n++) begin
      prev = cur;
      cur = nxt[cur];
    end
    if (cur != u) return;
    succ = nxt[u];
    if (prev < dles_pkg::NUM_UNITS) nxt[prev] = dles_pkg::LINK_BITS'(succ);
    else head = dles_pkg::LINK_BITS'(succ);
    if (succ < dles_pkg::NUM_UNITS) begin
      s = longint'(dlt[succ]) + dlt[u];
      dlt[succ] = (s > dles_pkg::DELAY_MAX) ? dles_pkg::DELAY_MAX
                : dles_pkg::DELAY_BITS'(s);
    end
    nxt[u] = dles_pkg::LIST_END;
    dlt[u] = '0;
    queued[u] = 0;
    if (count > 0) count--;
    reload();
  endfunction

  function void link_in(int u, longint d);
    int cur, prev;
    longint acc;
    if (queued[u]) return;
    cur = head;
    prev = dles_pkg::NUM_UNITS;
    acc = 0;
    for (int n = 0; n < dles_pkg::NUM_UNITS && cur < dles_pkg::NUM_UNITS; n++) begin
      if (d < acc + dlt[cur]) break;
      acc += dlt[cur];
      prev = cur;
      cur = nxt[cur];
    end
    if (cur >= dles_pkg::NUM_UNITS) cur = dles_pkg::NUM_UNITS;
    nxt[u] = dles_pkg::LINK_BITS'(cur);
    if (prev < dles_pkg::NUM_UNITS) nxt[prev] = dles_pkg::LINK_BITS'(u);
    else head = dles_pkg::LINK_BITS'(u);
    dlt[u] = dles_pkg::DELAY_BITS'(d - acc);
    if (cur < dles_pkg::NUM_UNITS) dlt[cur] = dlt[cur] - dlt[u];
    queued[u] = 1;
    count++;
    reload();
  endfunction

  function logic [dles_pkg::TTF_BITS-1:0] wait_of(int u);
    int cur;
    longint acc;
    cur = head;
    acc = 0;
    for (int n = 0; n < dles_pkg::NUM_UNITS && cur < dles_pkg::NUM_UNITS; n++) begin
      if (cur == head) begin
        if (cdown > 0) acc += cdown;
      end else begin
        acc += dlt[cur];
      end
      if (cur == u) begin
        return (acc + 1 > dles_pkg::TTF_MAX) ? dles_pkg::TTF_MAX
             : dles_pkg::TTF_BITS'(acc + 1);
      end
      cur = nxt[cur];
    end
    return '0;
  endfunction

  function void push(logic [dles_pkg::KIND_BITS-1:0] k, int u,
                     logic [dles_pkg::TTF_BITS-1:0] t, bit a, bit l);
    sched_result_t r;
    r.kind = k;
    r.unit = u[3:0];
    r.ttf = t;
    r.active = a;
    r.count = count[dles_pkg::COUNT_BITS-1:0];
    r.last = l;
    pending.push_back(r);
  endfunction

  // Note one accepted request and queue its results
  function void note_request(logic [dles_pkg::OP_BITS-1:0] op, logic [3:0] u,
                             logic [23:0] d);
    int fired, h;
    fired = 0;
    if (head < dles_pkg::NUM_UNITS) begin
      dlt[head] = (cdown < 0) ? '0 : (cdown > dles_pkg::DELAY_MAX) ? dles_pkg::DELAY_MAX
                : dles_pkg::DELAY_BITS'(cdown);
    end
    case (op)
      dles_pkg::OP_ACTIVATE: link_in(u, d);
      dles_pkg::OP_RESCHEDULE: begin
        unlink(u);
        link_in(u, d);
      end
      dles_pkg::OP_CANCEL: unlink(u);
      dles_pkg::OP_ADVANCE: begin
        cdown -= d;
        if (cdown <= 0) begin
          while (cdown <= 0 && head < dles_pkg::NUM_UNITS && fired < dles_pkg::NUM_UNITS) begin
            h = head;
            head = nxt[h];
            if (head >= dles_pkg::NUM_UNITS) head = dles_pkg::LIST_END;
            nxt[h] = dles_pkg::LIST_END;
            dlt[h] = '0;
            queued[h] = 0;
            if (count > 0) count--;
            reload();
            push(dles_pkg::KIND_FIRED, h, '0, 0, 0);
            fired++;
          end
          if (head >= dles_pkg::NUM_UNITS) cdown = idle_ival;
        end
        if (fired > 0) begin
          pending[$].last = 1;
          return;
        end
      end
      dles_pkg::OP_QUERY: begin
        push(dles_pkg::KIND_QUERY, u, wait_of(u), queued[u], 1);
        return;
      end
      default: ;
    endcase
    push(dles_pkg::KIND_ACK, u, '0, queued[u], 1);
  endfunction

  // One line per mismatch, counted
  task report(string msg);
    $display("%s", msg);
    errors++;
  endtask

  // Compare one accepted response with the oldest expectation
  task check_result(sched_result_t got);
    sched_result_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected response %p", got));
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      report($sformatf("mismatch: got %p want %p", got, want));
    end
  endtask
endclass

module tb;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  int   cycles = 0;
  bit   busy_hold = 0;

  dles_req_if req ();
  dles_rsp_if rsp ();
  dles_cfg_if cfg ();

  delta_list_event_scheduler uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  sched_scoreboard board = new();

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Mostly no gap or a short one, sometimes a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Response side: random stalls and checking
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else begin
      if (rsp.valid && rsp.ready)
        board.check_result({rsp.result_kind, rsp.unit_out, rsp.time_to_fire,
                            rsp.is_active, rsp.queue_count, rsp.last});
      rsp.ready <= busy_hold ? 1'b1 : ($urandom_range(0, 3) != 0 || $urandom_range(0, 9) == 0);
    end
  end

  // valid stays high into a back-to-back transaction; dropped only for a gap
  task automatic send(logic [dles_pkg::OP_BITS-1:0] op, logic [3:0] u, logic [23:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 0;
      repeat (g) @(posedge clk);
    end
    req.valid <= 1;
    req.operation <= op;
    req.unit <= u;
    req.delay <= d;
    do @(posedge clk); while (!req.ready);
    board.note_request(op, u, d);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_idle(logic [23:0] v);
    cfg.valid <= 1;
    cfg.idle_interval <= v;
    do @(posedge clk); while (!cfg.ready);
    board.set_idle(v);
    cfg.valid <= 0;
  endtask

  // Random delay: small mostly, with a few extremes
  function automatic logic [23:0] rnd_delay(int span);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 24'hFFFFFF;
    if (r == 1) return 24'($urandom());
    return 24'($urandom_range(0, span));
  endfunction

  task automatic random_phase(int n, int span);
    int r;
    logic [dles_pkg::OP_BITS-1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) op = dles_pkg::OP_ACTIVATE;
      else if (r < 45) op = dles_pkg::OP_RESCHEDULE;
      else if (r < 57) op = dles_pkg::OP_CANCEL;
      else if (r < 80) op = dles_pkg::OP_ADVANCE;
      else if (r < 96) op = dles_pkg::OP_QUERY;
      else op = dles_pkg::OP_BITS'($urandom_range(5, 7));
      send(op, 4'($urandom_range(0, 15)), rnd_delay(span));
    end
  endtask

  initial begin
    req.valid = 0;
    req.operation = '0;
    req.unit = '0;
    req.delay = '0;
    cfg.valid = 0;
    cfg.idle_interval = '0;
    board.clear();

    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, every operation, saturation, idle and unknown codes
    send(dles_pkg::OP_QUERY, 4'd0, 24'd0);
    send(dles_pkg::OP_ADVANCE, 4'd0, 24'd0);
    send(dles_pkg::OP_CANCEL, 4'd3, 24'd0);
    send(dles_pkg::OP_ACTIVATE, 4'd0, 24'd0);
    send(dles_pkg::OP_ACTIVATE, 4'd15, 24'hFFFFFF);
    send(dles_pkg::OP_ACTIVATE, 4'd7, 24'hFFFFFF);
    send(dles_pkg::OP_ACTIVATE, 4'd7, 24'd5);
    send(dles_pkg::OP_ACTIVATE, 4'd8, 24'hFFFFF0);
    send(dles_pkg::OP_QUERY, 4'd15, 24'hFFFFFF);
    send(dles_pkg::OP_QUERY, 4'd7, 24'd0);
    send(dles_pkg::OP_CANCEL, 4'd8, 24'd0);
    send(dles_pkg::OP_QUERY, 4'd7, 24'd0);
    send(dles_pkg::OP_RESCHEDULE, 4'd15, 24'd10);
    send(dles_pkg::OP_RESCHEDULE, 4'd3, 24'd2);
    send(3'd5, 4'd1, 24'hAAAAAA);
    send(3'd6, 4'd14, 24'h555555);
    send(3'd7, 4'd2, 24'd1);
    send(dles_pkg::OP_ADVANCE, 4'd0, 24'd1);
    send(dles_pkg::OP_ADVANCE, 4'd0, 24'hFFFFFF);
    send(dles_pkg::OP_QUERY, 4'd15, 24'd0);
    send(dles_pkg::OP_ADVANCE, 4'd0, 24'hFFFFFF);
    drain();

    // Random phases across idle_interval settings, smallest and largest too
    write_idle(24'd1);
    random_phase(50, 40);
    drain();
    write_idle(24'hFFFFFF);
    random_phase(50, 1000);
    drain();
    write_idle(24'($urandom_range(2, 500)));
    random_phase(50, 200);
    drain();
    write_idle(24'd1000000);
    random_phase(50, 24'hFFFFFF);

    req.valid <= 0;
    busy_hold = 1;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/dles_pkg.sv
rtl/core/dles_ifs.sv
rtl/core/delta_list_event_scheduler.sv
sim/tb.sv
